[rtl/trd_pkg.sv]
// Shared types and constants for the transitive reduction engine.
package trd_pkg;

   localparam int MAX_NODES_DEF  = 8;
   localparam int EVENT_BITS_DEF = 16;
   localparam int EVENT_BITS_MAX = 32;

   localparam int NODE_W  = 3;
   localparam int ROW_W   = 8;
   localparam int EVENT_W = 16;
   localparam int CSR_W   = 4;

   localparam logic [CSR_W-1:0] ACTIVE_RESET = 4'd8;

   localparam logic [1:0] MODE_EVENT = 2'd0;
   localparam logic [1:0] MODE_ROW   = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [NODE_W-1:0]  node_index;
      logic [EVENT_W-1:0] event_code;
      logic [ROW_W-1:0]   row_bits;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  from_index;
      logic [NODE_W-1:0]  to_index;
      logic [EVENT_W-1:0] from_event;
      logic [EVENT_W-1:0] to_event;
      logic               none_kept;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic load_event;
      logic load_row;
      logic reduce_start;
      logic reduce_step;
      logic emit_start;
      logic emit_step;
      logic emit_none;
   } cmd_type;

   typedef struct packed {
      logic reduce_done;
      logic any_kept;
      logic emit_done;
   } sts_type;

endpackage

[rtl/transitive_reduction_edges_top.sv]
// Busy stays low for load items.
// A run item reduces the adjacency rows, one adjacency row per cycle, then emits each
// kept edge, stepping row by row up to the last row with an edge.
// Each result shows on rsp_strobe in the cycle after it is formed; busy falls with the last.
// The receiver cannot stall, so every result leaves in the cycle it is formed for.
// Synchronous reset clears the adjacency rows, event valid flags and control; active_nodes is 8.
module transitive_reduction_edges_top #(
   parameter int MAX_NODES  = trd_pkg::MAX_NODES_DEF,
   parameter int EVENT_BITS = trd_pkg::EVENT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  trd_pkg::req_type          req_data,
   output logic                      rsp_strobe,
   output trd_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [trd_pkg::CSR_W-1:0] csr_data
);
   import trd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   trd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_data.mode),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   trd_datapath #(
      .MAX_NODES  (MAX_NODES),
      .EVENT_BITS (EVENT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .cmd        (cmd),
      .csr_write  (csr_valid & csr_ready),
      .csr_value  (csr_data),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/trd_ctrl.sv]
// Controller state machine sequencing loads, the reduction pass and edge emission.
module trd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       mode,
   input  trd_pkg::sts_type sts,
   output trd_pkg::cmd_type cmd,
   output logic             busy
);
   import trd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      accept;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode)
                  MODE_EVENT: cmd.load_event   = 1'b1;
                  MODE_ROW:   cmd.load_row     = 1'b1;
                  MODE_RUN:   cmd.reduce_start = 1'b1;
                  default:    cmd = '0;
               endcase
            end
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            if (sts.reduce_done) begin
               cmd.emit_start = sts.any_kept;
               cmd.emit_none  = ~sts.any_kept;
            end
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && mode == MODE_RUN) begin
                  state_ff <= ST_REDUCE;
                  busy_ff  <= 1'b1;
               end
            end
            ST_REDUCE: begin
               if (sts.reduce_done) begin
                  if (sts.any_kept) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_IDLE;
                     busy_ff  <= 1'b0;
                  end
               end
            end
            ST_EMIT: begin
               if (sts.emit_done) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

[rtl/trd_datapath.sv]
// Datapath holding the graph stores, the row reduction logic and the result register.
module trd_datapath #(
   parameter int MAX_NODES  = trd_pkg::MAX_NODES_DEF,
   parameter int EVENT_BITS = trd_pkg::EVENT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  trd_pkg::req_type         req,
   input  trd_pkg::cmd_type         cmd,
   input  logic                     csr_write,
   input  logic [trd_pkg::CSR_W-1:0] csr_value,
   output trd_pkg::sts_type         sts,
   output logic                     rsp_strobe,
   output trd_pkg::rsp_type         rsp_data
);
   import trd_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MAX_NODES - 1);

   logic [CSR_W-1:0]      active_ff;
   logic [MAX_NODES-1:0]  adj_ff [MAX_NODES];
   logic [EVENT_BITS-1:0] events_mem [MAX_NODES];
   logic [MAX_NODES-1:0]  ev_valid_ff;
   logic [MAX_NODES-1:0]  reduced_ff [MAX_NODES];
   logic [IDX_W-1:0]      row_ff;
   logic                  any_ff;
   logic [IDX_W-1:0]      em_row_ff;
   logic [MAX_NODES-1:0]  rem_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;

   logic [CNT_W-1:0]          n_eff;
   logic [MAX_NODES-1:0]      node_mask;
   logic [MAX_NODES-1:0]      cur_row;
   logic [MAX_NODES-1:0]      hit;
   logic [MAX_NODES-1:0]      keep;
   logic                      idx_ok;
   logic [IDX_W-1:0]          wr_idx;
   logic [EVENT_BITS_MAX-1:0] ev_wide;
   logic [IDX_W-1:0]          j_sel;
   logic [MAX_NODES-1:0]      rem_in;
   logic                      later_any;
   logic [EVENT_BITS_MAX-1:0] from_wide;
   logic [EVENT_BITS_MAX-1:0] to_wide;

   always_comb begin
      if (active_ff > CSR_W'(MAX_NODES)) begin
         n_eff = CNT_W'(MAX_NODES);
      end else begin
         n_eff = CNT_W'(active_ff);
      end
      for (int b = 0; b < MAX_NODES; b++) begin
         node_mask[b] = (CNT_W'(b) < n_eff);
      end
   end

   assign idx_ok  = (32'(req.node_index) < MAX_NODES);
   assign wr_idx  = req.node_index[IDX_W-1:0];
   assign ev_wide = EVENT_BITS_MAX'(req.event_code);

   always_comb begin
      cur_row = node_mask[row_ff] ? (adj_ff[row_ff] & node_mask) : '0;
      for (int j = 0; j < MAX_NODES; j++) begin
         hit[j] = 1'b0;
         for (int k = 0; k < MAX_NODES; k++) begin
            if (k != j) begin
               hit[j] = hit[j] | (cur_row[k] & adj_ff[k][j]);
            end
         end
      end
      keep = cur_row & ~hit;
   end

   always_comb begin
      j_sel = '0;
      for (int b = MAX_NODES - 1; b >= 0; b--) begin
         if (rem_ff[b]) begin
            j_sel = IDX_W'(b);
         end
      end
      rem_in    = rem_ff & (rem_ff - MAX_NODES'(1));
      later_any = 1'b0;
      for (int r = 0; r < MAX_NODES; r++) begin
         if (IDX_W'(r) > em_row_ff) begin
            later_any = later_any | (|reduced_ff[r]);
         end
      end
   end

   assign sts.reduce_done = (row_ff == LAST_ROW);
   assign sts.any_kept    = any_ff | (|keep);
   assign sts.emit_done   = (rem_in == '0) && !later_any;

   assign from_wide = ev_valid_ff[em_row_ff] ? EVENT_BITS_MAX'(events_mem[em_row_ff]) : '0;
   assign to_wide   = ev_valid_ff[j_sel] ? EVENT_BITS_MAX'(events_mem[j_sel]) : '0;

   always_ff @(posedge clock) begin
      if (cmd.load_event && idx_ok) begin
         events_mem[wr_idx] <= ev_wide[EVENT_BITS-1:0];
      end
      if (cmd.reduce_step) begin
         reduced_ff[row_ff] <= keep;
      end
      if (cmd.emit_none) begin
         rsp_ff.from_index <= '0;
         rsp_ff.to_index   <= '0;
         rsp_ff.from_event <= '0;
         rsp_ff.to_event   <= '0;
         rsp_ff.none_kept  <= 1'b1;
         rsp_ff.last       <= 1'b1;
      end else if (cmd.emit_step && rem_ff != '0) begin
         rsp_ff.from_index <= NODE_W'(em_row_ff);
         rsp_ff.to_index   <= NODE_W'(j_sel);
         rsp_ff.from_event <= from_wide[EVENT_W-1:0];
         rsp_ff.to_event   <= to_wide[EVENT_W-1:0];
         rsp_ff.none_kept  <= 1'b0;
         rsp_ff.last       <= (rem_in == '0) && !later_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= ACTIVE_RESET;
         ev_valid_ff   <= '0;
         row_ff        <= '0;
         any_ff        <= 1'b0;
         em_row_ff     <= '0;
         rem_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int r = 0; r < MAX_NODES; r++) begin
            adj_ff[r] <= '0;
         end
      end else begin
         rsp_strobe_ff <= cmd.emit_none || (cmd.emit_step && rem_ff != '0);
         if (csr_write) begin
            active_ff <= csr_value;
         end
         if (cmd.load_event && idx_ok) begin
            ev_valid_ff[wr_idx] <= 1'b1;
         end
         if (cmd.load_row && idx_ok) begin
            adj_ff[wr_idx] <= req.row_bits[MAX_NODES-1:0];
         end
         if (cmd.reduce_start) begin
            row_ff <= '0;
            any_ff <= 1'b0;
         end else if (cmd.reduce_step) begin
            row_ff <= row_ff + IDX_W'(1);
            any_ff <= any_ff | (|keep);
         end
         if (cmd.emit_start) begin
            em_row_ff <= '0;
            rem_ff    <= reduced_ff[0];
         end else if (cmd.emit_step) begin
            if (rem_ff != '0) begin
               rem_ff <= rem_in;
            end else if (later_any) begin
               em_row_ff <= em_row_ff + IDX_W'(1);
               rem_ff    <= reduced_ff[em_row_ff + IDX_W'(1)];
            end
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the transitive reduction edge emitter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import trd_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 80;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_W-1:0] SWEEP [5] = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd8};

   class reduction_scoreboard;
      logic [ROW_W-1:0]   adjacency [MAX_NODES_DEF];
      logic [EVENT_W-1:0] node_events [MAX_NODES_DEF];
      int unsigned        active_nodes;
      rsp_type            expected_edges [$];
      int                 mismatches;
      int                 items_seen;
      int                 runs;
      int                 edges_checked;
      int                 empty_results;

      function new();
         foreach (adjacency[i]) begin
            adjacency[i] = '0;
            node_events[i] = '0;
         end
         active_nodes = 32'(ACTIVE_RESET);
         mismatches = 0;
         items_seen = 0;
         runs = 0;
         edges_checked = 0;
         empty_results = 0;
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction

      task report_mismatch(string what, logic [39:0] got, logic [39:0] want);
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
         mismatches++;
      endtask

      function void reduce_and_queue_edges();
         int n;
         int total;
         int emitted;
         logic [ROW_W-1:0] row_limit;
         logic [ROW_W-1:0] row;
         logic [ROW_W-1:0] keep [MAX_NODES_DEF];
         rsp_type kept;
         n = (active_nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(active_nodes);
         row_limit = '0;
         for (int b = 0; b < n; b++) begin
            row_limit[b] = 1'b1;
         end
         total = 0;
         foreach (keep[i]) begin
            keep[i] = '0;
            if (i < n) begin
               row = adjacency[i] & row_limit;
               keep[i] = row;
               for (int j = 0; j < n; j++) begin
                  for (int k = 0; k < n; k++) begin
                     if (k != j && row[j] && row[k] && adjacency[k][j]) begin
                        keep[i][j] = 1'b0;
                     end
                  end
               end
               for (int j = 0; j < n; j++) begin
                  total += int'(keep[i][j]);
               end
            end
         end
         emitted = 0;
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               if (keep[i][j]) begin
                  emitted++;
                  kept = '0;
                  kept.from_index = NODE_W'(i);
                  kept.to_index = NODE_W'(j);
                  kept.from_event = node_events[i];
                  kept.to_event = node_events[j];
                  kept.last = (emitted == total);
                  expected_edges.push_back(kept);
               end
            end
         end
         if (total == 0) begin
            kept = '0;
            kept.none_kept = 1'b1;
            kept.last = 1'b1;
            expected_edges.push_back(kept);
         end
         runs++;
      endfunction

      function void note_item(req_type item);
         if (item.mode != MODE_UNUSED) begin
            items_seen++;
         end
         case (item.mode)
            MODE_EVENT: begin
               node_events[item.node_index] = item.event_code;
            end
            MODE_ROW: begin
               adjacency[item.node_index] = item.row_bits;
            end
            MODE_RUN: begin
               reduce_and_queue_edges();
            end
            default: begin
            end
         endcase
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_edges.size() == 0) begin
            report_mismatch("result with nothing expected", got, '0);
            return;
         end
         want = expected_edges.pop_front();
         if (got.from_index !== want.from_index) begin
            report_mismatch("from_index", 40'(got.from_index), 40'(want.from_index));
         end
         if (got.to_index !== want.to_index) begin
            report_mismatch("to_index", 40'(got.to_index), 40'(want.to_index));
         end
         if (got.from_event !== want.from_event) begin
            report_mismatch("from_event", 40'(got.from_event), 40'(want.from_event));
         end
         if (got.to_event !== want.to_event) begin
            report_mismatch("to_event", 40'(got.to_event), 40'(want.to_event));
         end
         if (got.none_kept !== want.none_kept) begin
            report_mismatch("none_kept", 40'(got.none_kept), 40'(want.none_kept));
         end
         if (got.last !== want.last) begin
            report_mismatch("last", 40'(got.last), 40'(want.last));
         end
         if (want.none_kept) begin
            empty_results++;
         end else begin
            edges_checked++;
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data;

   reduction_scoreboard board;
   int idle_pct;
   int csr_writes;
   int cycle_count;
   int random_items;

   transitive_reduction_edges_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_item(req_data);
         end
         if (csr_valid && csr_ready) begin
            board.active_nodes = 32'(csr_data);
            csr_writes++;
         end
         if (rsp_strobe) begin
            board.check_result(rsp_data);
         end
      end
   end

   function automatic req_type make_item(logic [1:0] mode, logic [NODE_W-1:0] node,
                                         logic [EVENT_W-1:0] code, logic [ROW_W-1:0] row);
      req_type item;
      item.mode = mode;
      item.node_index = node;
      item.event_code = code;
      item.row_bits = row;
      return item;
   endfunction

   task automatic send_item(req_type item);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int loads;
      int pick;
      int phase;
      int graphs;
      logic [NODE_W-1:0] node;
      logic [EVENT_W-1:0] code;
      logic [ROW_W-1:0] row;
      logic [CSR_W-1:0] setting;

      board = new();
      idle_pct = 16;
      csr_writes = 0;
      cycle_count = 0;
      random_items = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // An empty graph at the reset setting must give the single empty result.
      send_item(make_item(MODE_RUN, 3'd0, 16'h0000, 8'h00));
      send_item(make_item(MODE_EVENT, 3'd0, 16'h0000, 8'h00));
      send_item(make_item(MODE_EVENT, 3'd1, 16'hFFFF, 8'h00));
      send_item(make_item(MODE_EVENT, 3'd2, 16'hAAAA, 8'h00));
      send_item(make_item(MODE_EVENT, 3'd3, 16'h5555, 8'h00));
      send_item(make_item(MODE_EVENT, 3'd7, 16'h8001, 8'h00));
      // A shortcut edge over a chain, a self loop that hides its neighbor, a full row.
      send_item(make_item(MODE_ROW, 3'd0, 16'h0000, 8'h06));
      send_item(make_item(MODE_ROW, 3'd1, 16'h0000, 8'h04));
      send_item(make_item(MODE_ROW, 3'd3, 16'h0000, 8'h18));
      send_item(make_item(MODE_ROW, 3'd7, 16'h0000, 8'hFF));
      send_item(make_item(MODE_ROW, 3'd4, 16'h0000, 8'h00));
      send_item(make_item(MODE_UNUSED, 3'd5, 16'hFFFF, 8'hFF));
      send_item(make_item(MODE_RUN, 3'd0, 16'h0000, 8'h00));
      send_item(make_item(MODE_ROW, 3'd0, 16'h0000, 8'h07));
      foreach (SWEEP[s]) begin
         drain();
         write_active(SWEEP[s]);
         send_item(make_item(MODE_RUN, 3'd7, 16'hFFFF, 8'hFF));
      end

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         idle_pct = (phase >= 2 && phase <= 4) ? 0 : 16;
         case ($urandom_range(5))
            0: setting = 4'd0;
            1: setting = 4'd1;
            2: setting = 4'd15;
            default: setting = CSR_W'($urandom_range(4, 8));
         endcase
         drain();
         write_active(setting);
         graphs = $urandom_range(1, 3);
         repeat (graphs) begin
            loads = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
            repeat (loads) begin
               pick = $urandom_range(99);
               node = NODE_W'($urandom_range(7));
               code = EVENT_W'($urandom);
               if ($urandom_range(9) == 0) begin
                  code = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               end
               row = ROW_W'($urandom);
               if ($urandom_range(1)) begin
                  row = row & (8'hFF << (node + 1));
               end
               if (pick < 30) begin
                  send_item(make_item(MODE_EVENT, node, code, row));
                  random_items++;
               end else if (pick < 92) begin
                  send_item(make_item(MODE_ROW, node, code, row));
                  random_items++;
               end else begin
                  send_item(make_item(MODE_UNUSED, node, code, row));
               end
            end
            send_item(make_item(MODE_RUN, NODE_W'($urandom_range(7)), EVENT_W'($urandom),
                                ROW_W'($urandom)));
            random_items++;
         end
         phase++;
      end

      drain();
      $display("Covered %0d transactions with %0d reduction runs and %0d register writes.",
               board.items_seen, board.runs, csr_writes);
      $display("Checked %0d kept edges and %0d empty-graph results.",
               board.edges_checked, board.empty_results);
      if (board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
